// File: rtl/strict_version_triple_parser_macros.svh
`ifndef STRICT_VERSION_TRIPLE_PARSER_MACROS_SVH
`define STRICT_VERSION_TRIPLE_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SVTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svtp assertion failed");

// next-cycle implication
`define SVTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svtp assertion failed");

`endif

// File: rtl/svtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svtp_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int OUT_W = 32;

	localparam logic [7:0] CH_V = 8'h76;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [1:0] FIRST_PART = 2'd0;
	localparam logic [1:0] LAST_PART = 2'd2;

	typedef struct packed {
		logic [7:0] char_byte;
		logic is_last;
	} in_word_t;

	typedef struct packed {
		logic valid_res;
		logic [OUT_W-1:0] major;
		logic [OUT_W-1:0] minor;
		logic [OUT_W-1:0] patch;
	} out_word_t;

endpackage

`default_nettype wire

// File: rtl/svtp_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "strict_version_triple_parser_macros.svh"

module svtp_core #(
	parameter int VALUE_BITS = svtp_pkg::VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire svtp_pkg::in_word_t word,
	output svtp_pkg::out_word_t res
);
	import svtp_pkg::*;

	localparam int WB = VALUE_BITS + 4;

	logic at_start_q;
	logic [1:0] idx_q;
	logic [VALUE_BITS-1:0] major_q;
	logic [VALUE_BITS-1:0] minor_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic nonempty_q;
	logic lzero_q;
	logic failed_q;

	logic [1:0] idx_n;
	logic [VALUE_BITS-1:0] major_n;
	logic [VALUE_BITS-1:0] minor_n;
	logic [VALUE_BITS-1:0] acc_n;
	logic nonempty_n;
	logic lzero_n;
	logic failed_n;

	logic is_digit;
	logic [3:0] dval;
	logic [WB-1:0] acc_ext;
	logic [WB-1:0] prod;
	logic ovf;
	logic ok;

	assign is_digit = (word.char_byte >= CH_ZERO) && (word.char_byte <= CH_NINE);
	assign dval = word.char_byte[3:0];
	assign acc_ext = {4'b0000, acc_q};
	assign prod = (acc_ext << 3) + (acc_ext << 1) + WB'(dval);
	assign ovf = |prod[WB-1:VALUE_BITS];

	always_comb begin
		idx_n = idx_q;
		major_n = major_q;
		minor_n = minor_q;
		acc_n = acc_q;
		nonempty_n = nonempty_q;
		lzero_n = lzero_q;
		failed_n = failed_q;
		if (!failed_q && !(at_start_q && word.char_byte == CH_V)) begin
			if (is_digit) begin
				if (lzero_q || ovf) begin
					failed_n = 1'b1;
				end else begin
					lzero_n = lzero_q | (!nonempty_q && dval == 4'd0);
					acc_n = prod[VALUE_BITS-1:0];
					nonempty_n = 1'b1;
				end
			end else if (word.char_byte == CH_DOT) begin
				if (!nonempty_q || idx_q >= LAST_PART) begin
					failed_n = 1'b1;
				end else begin
					if (idx_q == FIRST_PART) begin
						major_n = acc_q;
					end else begin
						minor_n = acc_q;
					end
					idx_n = idx_q + 2'd1;
					acc_n = '0;
					nonempty_n = 1'b0;
					lzero_n = 1'b0;
				end
			end else begin
				failed_n = 1'b1;
			end
		end
	end

	assign ok = !failed_n && idx_n == LAST_PART && nonempty_n;

	always_comb begin
		res.valid_res = ok;
		res.major = ok ? OUT_W'(major_n) : '0;
		res.minor = ok ? OUT_W'(minor_n) : '0;
		res.patch = ok ? OUT_W'(acc_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			idx_q <= FIRST_PART;
			major_q <= '0;
			minor_q <= '0;
			acc_q <= '0;
			nonempty_q <= 1'b0;
			lzero_q <= 1'b0;
			failed_q <= 1'b0;
		end else if (take) begin
			if (word.is_last) begin
				at_start_q <= 1'b1;
				idx_q <= FIRST_PART;
				major_q <= '0;
				minor_q <= '0;
				acc_q <= '0;
				nonempty_q <= 1'b0;
				lzero_q <= 1'b0;
				failed_q <= 1'b0;
			end else begin
				at_start_q <= 1'b0;
				idx_q <= idx_n;
				major_q <= major_n;
				minor_q <= minor_n;
				acc_q <= acc_n;
				nonempty_q <= nonempty_n;
				lzero_q <= lzero_n;
				failed_q <= failed_n;
			end
		end
	end

	`SVTP_ASSERT_NOW(a_idx_range, 1'b1, idx_q != 2'd3)
	`SVTP_ASSERT_NOW(a_lzero_nonempty, lzero_q, nonempty_q)
	`SVTP_ASSERT_NEXT(a_last_clears, take && word.is_last, at_start_q && !failed_q)

endmodule

`default_nettype wire

// File: rtl/strict_version_triple_parser.sv
// Strict version triple parser.
// Channel char: one character per word (char_word.char_byte), with
// char_word.is_last set on the final character of a version string.
// Channel res: one word per string, sent for its final character:
// valid_res and the major, minor and patch numbers (zero when invalid).
// A single leading 'v' is skipped; three dot-separated decimal parts with
// no leading zeros, each fitting in VALUE_BITS bits, are required.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// Throughput: one character per cycle while char_stall is low. The final
// character passes the input register, then the digit step and the result
// register, before its result appears.
// Reset clears the parse state and empties both registers.
// When res stalls, the held result stays put; non-final characters keep
// flowing, and the next final character waits in the input register and
// raises char_stall until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_version_triple_parser_macros.svh"

module strict_version_triple_parser #(
	parameter int VALUE_BITS = svtp_pkg::VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic char_valid,
	output logic char_stall,
	input wire svtp_pkg::in_word_t char_word,
	output logic res_valid,
	input wire logic res_stall,
	output svtp_pkg::out_word_t res_word
);
	import svtp_pkg::*;

	logic vld_s1;
	in_word_t word_s1;
	logic advance;
	out_word_t step_res;

	assign advance = vld_s1 && (!word_s1.is_last || !res_valid || !res_stall);
	assign char_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!char_stall) begin
			vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			word_s1 <= char_word;
		end
	end

	svtp_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(advance),
		.word(word_s1),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance && word_s1.is_last) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.is_last) begin
			res_word <= step_res;
		end
	end

	`SVTP_ASSERT_NOW(a_stall_cause, char_stall,
		vld_s1 && word_s1.is_last && res_valid && res_stall)
	`SVTP_ASSERT_NEXT(a_last_loads, advance && word_s1.is_last, res_valid)
	`SVTP_ASSERT_NOW(a_invalid_zero, res_valid && !res_word.valid_res,
		res_word.major == '0 && res_word.minor == '0 && res_word.patch == '0)

endmodule

`default_nettype wire
